// File: hw/rtl/gsn_pkg.sv
`timescale 1ns / 1ps

package gsn_pkg;

  // Field and datapath widths
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned SIDE_W   = 11;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned IDX_W    = 31;
  localparam int unsigned BASE_W   = 30;
  localparam int unsigned SQ_W     = 21;
  localparam int unsigned MUL_W    = 32;
  localparam int unsigned SLOTS    = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned CFG_AW   = 1;
  localparam int unsigned QDEPTH   = 2;

  localparam int unsigned MAX_SIDE_DEF = 1024;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_MODE = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_SIDE = 1'd1;

  // Stencil modes
  localparam logic [MODE_W-1:0] MODE_MESH5  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TORUS5 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MESH7  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MESH9  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CUBE   = 3'd4;

  // Offset term applied to the node base index
  typedef enum logic [1:0] {
    SelZero,
    SelN,
    SelNn,
    SelNnm
  } gsn_sel_e;

  typedef struct packed {
    gsn_sel_e   add_sel;
    gsn_sel_e   sub_sel;
    logic [1:0] k;
  } gsn_term_t;

  // One classified node, handed from front to back
  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [SIDE_W-1:0] n;
    logic [SQ_W-1:0]   nn;
    logic [SQ_W-1:0]   nnm;
    logic [SLOTS-1:0]  mask;
    logic [MODE_W-1:0] mode;
  } gsn_job_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             present;
    logic             last;
  } gsn_result_t;

  function automatic gsn_term_t gsn_mk(gsn_sel_e a, gsn_sel_e s, logic [1:0] k);
    gsn_term_t t;
    t.add_sel = a;
    t.sub_sel = s;
    t.k       = k;
    return t;
  endfunction

  // Neighbor index = base + add - sub + k, per mode and slot.
  // Torus slots come in pairs: plain step, then the wrapped step.
  function automatic gsn_term_t gsn_term(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot);
    gsn_term_t t;
    t = gsn_mk(SelZero, SelZero, 2'd0);
    case (mode)
      MODE_MESH5, MODE_MESH7, MODE_MESH9: begin
        case (slot)
          3'd0: t = gsn_mk(SelZero, SelN, 2'd1);
          3'd1: t = gsn_mk(SelN, SelZero, 2'd1);
          3'd2: t = gsn_mk(SelZero, SelZero, 2'd0);
          3'd3: t = gsn_mk(SelZero, SelZero, 2'd2);
          3'd4: t = gsn_mk(SelZero, SelN, 2'd0);
          3'd5: t = gsn_mk(SelN, SelZero, 2'd2);
          3'd6: t = gsn_mk(SelZero, SelN, 2'd2);
          default: t = gsn_mk(SelN, SelZero, 2'd0);
        endcase
      end
      MODE_TORUS5: begin
        case (slot)
          3'd0: t = gsn_mk(SelZero, SelN, 2'd1);
          3'd1: t = gsn_mk(SelNnm, SelZero, 2'd1);
          3'd2: t = gsn_mk(SelN, SelZero, 2'd1);
          3'd3: t = gsn_mk(SelZero, SelNnm, 2'd1);
          3'd4: t = gsn_mk(SelZero, SelZero, 2'd0);
          3'd5: t = gsn_mk(SelN, SelZero, 2'd0);
          3'd6: t = gsn_mk(SelZero, SelZero, 2'd2);
          default: t = gsn_mk(SelZero, SelN, 2'd2);
        endcase
      end
      MODE_CUBE: begin
        case (slot)
          3'd0: t = gsn_mk(SelZero, SelNn, 2'd1);
          3'd1: t = gsn_mk(SelNn, SelZero, 2'd1);
          3'd2: t = gsn_mk(SelZero, SelN, 2'd1);
          3'd3: t = gsn_mk(SelN, SelZero, 2'd1);
          3'd4: t = gsn_mk(SelZero, SelZero, 2'd0);
          3'd5: t = gsn_mk(SelZero, SelZero, 2'd2);
          default: t = gsn_mk(SelZero, SelZero, 2'd0);
        endcase
      end
      default: t = gsn_mk(SelZero, SelZero, 2'd0);
    endcase
    return t;
  endfunction

endpackage

// File: hw/rtl/grid_stencil_neighbor_generator.sv
`timescale 1ns / 1ps
// Channel | Handshake                        | Payload
// node in | push_i / full_o                  | row_i, col_i, layer_i
// result  | empty_o / pop_i                  | neighbor_index_o, present_o, last_of_node_o
// config  | cfg_valid_i / cfg_ready_o        | cfg_addr_i, cfg_data_i
//
// Nodes enter one per cycle while full_o is low, through a three-stage classify
// pipeline; the result generator then emits one beat per cycle unless the result
// queue is full, so a node yields max(1, neighbor count) beats, 1 to 8.
// Path to a result: classify stages, job queue, back-end job register, result queue.
// Reset clears mode to mesh5 and side length to 1; config writes take effect
// at once. A full result queue stalls the back end, and a full job queue
// stalls the front pipeline and raises full_o while stage 3 holds a node.

module grid_stencil_neighbor_generator #(
  parameter int unsigned MAX_SIDE = gsn_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gsn_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [gsn_pkg::SIDE_W-1:0]   cfg_data_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [gsn_pkg::COORD_W-1:0]  row_i,
  input  logic [gsn_pkg::COORD_W-1:0]  col_i,
  input  logic [gsn_pkg::COORD_W-1:0]  layer_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [gsn_pkg::IDX_W-1:0]    neighbor_index_o,
  output logic                         present_o,
  output logic                         last_of_node_o
);

  import gsn_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic [SIDE_W-1:0] side_q;

  logic        job_push, job_full, job_pop, job_empty;
  gsn_job_t    job_w, job_r;
  logic        res_push, res_full;
  gsn_result_t res_w, res_r;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MESH5;
      side_q <= SIDE_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_SIDE: side_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gsn_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_mode_i (mode_q),
    .cfg_side_i (side_q),
    .push_i     (push_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .layer_i    (layer_i),
    .full_o     (full_o),
    .job_push_o (job_push),
    .job_o      (job_w),
    .job_full_i (job_full)
  );

  gsn_queue #(
    .WIDTH($bits(gsn_job_t)),
    .DEPTH(QDEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_w),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_r),
    .empty_o (job_empty)
  );

  gsn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_r),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_o       (res_w),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  gsn_queue #(
    .WIDTH($bits(gsn_result_t)),
    .DEPTH(QDEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_w),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_r),
    .empty_o (empty_o)
  );

  assign neighbor_index_o = res_r.index;
  assign present_o        = res_r.present;
  assign last_of_node_o   = res_r.last;

endmodule

// File: hw/rtl/gsn_queue.sv
`timescale 1ns / 1ps

module gsn_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = gsn_pkg::QDEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/gsn_front.sv
`timescale 1ns / 1ps

module gsn_front #(
  parameter int unsigned MAX_SIDE = gsn_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [gsn_pkg::MODE_W-1:0]       cfg_mode_i,
  input  logic [gsn_pkg::SIDE_W-1:0]       cfg_side_i,
  input  logic                             push_i,
  input  logic [gsn_pkg::COORD_W-1:0]      row_i,
  input  logic [gsn_pkg::COORD_W-1:0]      col_i,
  input  logic [gsn_pkg::COORD_W-1:0]      layer_i,
  output logic                             full_o,
  output logic                             job_push_o,
  output gsn_pkg::gsn_job_t                job_o,
  input  logic                             job_full_i
);

  import gsn_pkg::*;

  localparam logic [SIDE_W-1:0] MaxSideL = SIDE_W'(MAX_SIDE);

  logic                advance, accept;
  logic [SIDE_W-1:0]   n_eff;
  logic [COORD_W-1:0]  r_cl, c_cl, l_cl;

  // Stage 1: clamped coordinates
  logic                v1_q;
  logic [COORD_W-1:0]  r1_q, c1_q, l1_q;
  logic [SIDE_W-1:0]   n1_q;
  logic [MODE_W-1:0]   mode1_q;

  // Stage 2: row product, side square, neighbor mask
  logic                v2_q;
  logic [SQ_W-1:0]     rn2_q, nn2_q;
  logic [COORD_W-1:0]  c2_q, l2_q;
  logic [SIDE_W-1:0]   n2_q;
  logic [MODE_W-1:0]   mode2_q;
  logic [SLOTS-1:0]    mask2_q, mask_d;
  logic [SIDE_W-1:0]   last1;
  logic                r_gt, r_lt, c_gt, c_lt, l_gt, l_lt;

  // Stage 3: 2-D base index
  logic                v3_q;
  logic [SQ_W-1:0]     base2_3_q, nnm3_q, nn3_q;
  logic [COORD_W-1:0]  l3_q;
  logic [SIDE_W-1:0]   n3_q;
  logic [MODE_W-1:0]   mode3_q;
  logic [SLOTS-1:0]    mask3_q;
  logic [MUL_W-1:0]    base3;

  // Move the whole pipe unless the last stage is blocked
  assign advance = !v3_q || !job_full_i;
  assign full_o  = !advance;
  assign accept  = push_i && advance;

  // Effective side length and coordinate clamp
  always_comb begin
    if (cfg_side_i == '0) begin
      n_eff = SIDE_W'(1);
    end else if (cfg_side_i > MaxSideL) begin
      n_eff = MaxSideL;
    end else begin
      n_eff = cfg_side_i;
    end
    r_cl = ({1'b0, row_i} >= n_eff) ? COORD_W'(n_eff - 1'b1) : row_i;
    c_cl = ({1'b0, col_i} >= n_eff) ? COORD_W'(n_eff - 1'b1) : col_i;
    l_cl = ({1'b0, layer_i} >= n_eff) ? COORD_W'(n_eff - 1'b1) : layer_i;
  end

  // Classify edges and build the slot mask
  always_comb begin
    last1  = n1_q - 1'b1;
    r_gt   = (r1_q != '0);
    c_gt   = (c1_q != '0);
    l_gt   = (l1_q != '0);
    r_lt   = ({1'b0, r1_q} < last1);
    c_lt   = ({1'b0, c1_q} < last1);
    l_lt   = ({1'b0, l1_q} < last1);
    mask_d = '0;
    case (mode1_q)
      MODE_MESH5: mask_d = {4'b0, c_lt, c_gt, r_lt, r_gt};
      MODE_MESH7: mask_d = {2'b0, r_lt & c_lt, r_gt & c_gt, c_lt, c_gt, r_lt, r_gt};
      MODE_MESH9: mask_d = {r_lt & c_gt, r_gt & c_lt, r_lt & c_lt, r_gt & c_gt,
                            c_lt, c_gt, r_lt, r_gt};
      MODE_TORUS5: mask_d = {!c_lt, c_lt, !c_gt, c_gt, !r_lt, r_lt, !r_gt, r_gt};
      MODE_CUBE: mask_d = {2'b0, l_lt, l_gt, c_lt, c_gt, r_lt, r_gt};
      default: mask_d = '0;
    endcase
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (advance) begin
      r1_q      <= r_cl;
      c1_q      <= c_cl;
      l1_q      <= l_cl;
      n1_q      <= n_eff;
      mode1_q   <= cfg_mode_i;

      rn2_q     <= SQ_W'(r1_q) * SQ_W'(n1_q);
      nn2_q     <= SQ_W'(n1_q) * SQ_W'(n1_q);
      c2_q      <= c1_q;
      l2_q      <= l1_q;
      n2_q      <= n1_q;
      mode2_q   <= mode1_q;
      mask2_q   <= mask_d;

      base2_3_q <= rn2_q + SQ_W'(c2_q);
      nnm3_q    <= nn2_q - SQ_W'(n2_q);
      nn3_q     <= nn2_q;
      l3_q      <= l2_q;
      n3_q      <= n2_q;
      mode3_q   <= mode2_q;
      mask3_q   <= mask2_q;
    end
  end

  // 3-D base index and job hand-off
  assign base3 = MUL_W'(base2_3_q) * MUL_W'(n3_q) + MUL_W'(l3_q);

  assign job_push_o = v3_q;
  always_comb begin
    job_o.base = (mode3_q == MODE_CUBE) ? BASE_W'(base3) : BASE_W'(base2_3_q);
    job_o.n    = n3_q;
    job_o.nn   = nn3_q;
    job_o.nnm  = nnm3_q;
    job_o.mask = mask3_q;
    job_o.mode = mode3_q;
  end

endmodule

// File: hw/rtl/gsn_back.sv
`timescale 1ns / 1ps

module gsn_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gsn_pkg::gsn_job_t     job_i,
  input  logic                  job_empty_i,
  output logic                  job_pop_o,
  output gsn_pkg::gsn_result_t  res_o,
  output logic                  res_push_o,
  input  logic                  res_full_i
);

  import gsn_pkg::*;

  logic              act_q;
  gsn_job_t          job_q;
  logic [SLOTS-1:0]  rem_q, rem_next;
  logic [SLOT_W-1:0] slot;
  gsn_term_t         term;
  logic [IDX_W-1:0]  add_v, sub_v, idx;
  logic              emit, last, finish, load;

  // Pick the lowest pending slot
  always_comb begin
    slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        slot = SLOT_W'(i);
      end
    end
  end

  // Offset selection and index add
  always_comb begin
    term = gsn_term(job_q.mode, slot);
    case (term.add_sel)
      SelN:    add_v = IDX_W'(job_q.n);
      SelNn:   add_v = IDX_W'(job_q.nn);
      SelNnm:  add_v = IDX_W'(job_q.nnm);
      default: add_v = '0;
    endcase
    case (term.sub_sel)
      SelN:    sub_v = IDX_W'(job_q.n);
      SelNn:   sub_v = IDX_W'(job_q.nn);
      SelNnm:  sub_v = IDX_W'(job_q.nnm);
      default: sub_v = '0;
    endcase
    idx = IDX_W'(job_q.base) + add_v - sub_v + IDX_W'(term.k);
  end

  // Emit one beat per cycle while active and the result queue is not full
  assign rem_next   = rem_q & (rem_q - 1'b1);
  assign last       = (rem_next == '0);
  assign emit       = act_q && !res_full_i;
  assign finish     = emit && last;
  assign load       = (!act_q || finish) && !job_empty_i;
  assign job_pop_o  = load;
  assign res_push_o = emit;

  always_comb begin
    res_o.present = (rem_q != '0);
    res_o.index   = res_o.present ? idx : '0;
    res_o.last    = last;
  end

  // Hold job, drop served slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (load) begin
      act_q <= 1'b1;
    end else if (finish) begin
      act_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
      rem_q <= job_i.mask;
    end else if (emit) begin
      rem_q <= rem_next;
    end
  end

  a_absent_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && !res_o.present |-> res_o.last)
    else $error("not-present beat without last flag");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && !res_o.present |-> res_o.index == '0)
    else $error("not-present beat with nonzero index");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q && !res_push_o |=> act_q && $stable(rem_q))
    else $error("active job changed while output stalled");

endmodule
